@@ rtl/core/stc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants of the two-motor trapezoidal ramp controller:
// word layouts, command, phase and status codes, register indexes, reset
// values and the controller-to-datapath command and status groups.
// ----------------------------------------------------------------------------
package stc_pkg;

   localparam int CSR_DATA_W = 31;
   localparam int DEN_W      = 16;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_MOVE  = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_CHECK = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      PH_SLEEP  = 3'd0,
      PH_ACCEL  = 3'd1,
      PH_CRUISE = 3'd2,
      PH_DECEL  = 3'd3,
      PH_SLOW   = 3'd4,
      PH_STOP   = 3'd5,
      PH_STOPZ  = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      MS_OK        = 3'd0,
      MS_BUSY      = 3'd1,
      MS_ZERO      = 3'd2,
      MS_TOO_BIG   = 3'd3,
      MS_ON_SWITCH = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd3
   } dir_type;

   typedef enum logic [2:0] {
      CSR_FASTEST_A  = 3'd0,
      CSR_FASTEST_B  = 3'd1,
      CSR_TRAVEL_A   = 3'd2,
      CSR_TRAVEL_B   = 3'd3,
      CSR_REVERSE_A  = 3'd4,
      CSR_REVERSE_B  = 3'd5,
      CSR_RAMP_STEPS = 3'd6,
      CSR_MICROSTEPS = 3'd7
   } csr_index_type;

   localparam logic [12:0] FASTEST_RESET    = 13'd500;
   localparam logic [15:0] RAMP_STEPS_RESET = 16'd100;
   localparam logic [7:0]  MICROSTEPS_RESET = 8'd16;
   localparam logic [15:0] PERIOD_RESET     = 16'd1000;
   localparam logic [31:0] POSITION_RESET   = 32'hFFFF_FFFF;
   localparam logic [12:0] PERIOD_FLOOR     = 13'd2;

   typedef struct packed {
      command_type        command;
      logic               motor;
      logic signed [31:0] move_steps;
      logic               zero_switch_hit;
      logic               far_switch_hit;
   } req_word_type;

   typedef struct packed {
      status_type         move_status;
      phase_type          phase;
      logic [15:0]        timer_period;
      logic               motor_enable;
      logic               direction_level;
      logic signed [31:0] position;
      logic [31:0]        steps_remaining;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic move_ok;
      logic div_busy;
   } dp_status_type;

endpackage

@@ rtl/core/stc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_div
// Restoring divider, one quotient bit per cycle, used for the ramp increment.
// ----------------------------------------------------------------------------
module stc_div #(
   parameter int NUM_W = 17
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [NUM_W-1:0]                numer,
   input  logic [stc_pkg::DEN_W-1:0]       denom,
   output logic                            busy,
   output logic [NUM_W-1:0]                quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]              quo_ff, quo_in;
   logic [stc_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic [stc_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic [stc_pkg::DEN_W:0]       trial;
   logic [stc_pkg::DEN_W:0]       trial_diff;
   logic                          ge;

   always_comb begin
      trial      = {rem_ff, quo_ff[NUM_W-1]};
      trial_diff = trial - {1'b0, den_ff};
      ge         = (trial >= {1'b0, den_ff});
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      if (start) begin
         quo_in  = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         rem_in  = ge ? trial_diff[stc_pkg::DEN_W-1:0] : trial[stc_pkg::DEN_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/core/stc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_dp
// Datapath: settings registers, per-motor motion state, move checks, tick
// update, ramp increment divider and the result register.
// ----------------------------------------------------------------------------
module stc_dp #(
   parameter int SLOW_DIV = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  stc_pkg::csr_index_type            csr_index,
   input  logic [stc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  stc_pkg::req_word_type             req_word,
   input  stc_pkg::ctrl_cmd_type             cmd,
   output stc_pkg::dp_status_type            status,
   output stc_pkg::rsp_word_type             rsp_word
);

   localparam int PROD_W = 13 + $clog2(SLOW_DIV);

   // settings
   logic [12:0] fastest_ff [2];
   logic [30:0] travel_ff  [2];
   logic        reverse_ff [2];
   logic [15:0] ramp_ff;
   logic [7:0]  micro_ff;

   // per-motor state
   stc_pkg::phase_type phase_ff  [2];
   logic [31:0]        pos_ff    [2];
   logic [31:0]        steps_ff  [2];
   logic [7:0]         cnt_ff    [2];
   stc_pkg::dir_type   dir_ff    [2];
   logic [15:0]        period_ff [2];
   logic [15:0]        inc_ff    [2];
   logic               en_ff     [2];
   logic               pin_ff    [2];

   stc_pkg::req_word_type req_ff;
   stc_pkg::rsp_word_type rsp_ff;

   stc_pkg::phase_type  phase_in;
   logic [31:0]         pos_in;
   logic [31:0]         steps_in;
   logic [7:0]          cnt_in;
   stc_pkg::dir_type    dir_in;
   logic [15:0]         period_in;
   logic [15:0]         inc_in;
   logic                en_in;
   logic                pin_in;
   stc_pkg::status_type move_status_in;

   logic                motor_sel;
   stc_pkg::phase_type  cur_phase;
   stc_pkg::dir_type    cur_dir;
   logic [12:0]         fp;
   logic [12:0]         low_p;
   logic [15:0]         low_ext;
   logic [PROD_W-1:0]   prod_high;
   logic [15:0]         high_p;
   logic [PROD_W-1:0]   div_numer;
   logic [15:0]         div_denom;
   logic                div_busy;
   logic [PROD_W-1:0]   quotient;
   logic [31:0]         inc_wide;
   logic [15:0]         inc_sat;
   logic [31:0]         raw_u;
   logic                down;
   logic [31:0]         mag;
   stc_pkg::status_type move_check;
   logic                short_move;
   logic [7:0]          cnt_inc;
   logic [31:0]         steps_dec;
   logic [15:0]         arr_dn;
   logic [15:0]         arr_up;

   always_ff @(posedge clock) begin
      if (reset) begin
         fastest_ff[0] <= stc_pkg::FASTEST_RESET;
         fastest_ff[1] <= stc_pkg::FASTEST_RESET;
         travel_ff[0]  <= '0;
         travel_ff[1]  <= '0;
         reverse_ff[0] <= 1'b0;
         reverse_ff[1] <= 1'b0;
         ramp_ff       <= stc_pkg::RAMP_STEPS_RESET;
         micro_ff      <= stc_pkg::MICROSTEPS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            stc_pkg::CSR_FASTEST_A:  fastest_ff[0] <= csr_wdata[12:0];
            stc_pkg::CSR_FASTEST_B:  fastest_ff[1] <= csr_wdata[12:0];
            stc_pkg::CSR_TRAVEL_A:   travel_ff[0]  <= csr_wdata[30:0];
            stc_pkg::CSR_TRAVEL_B:   travel_ff[1]  <= csr_wdata[30:0];
            stc_pkg::CSR_REVERSE_A:  reverse_ff[0] <= csr_wdata[0];
            stc_pkg::CSR_REVERSE_B:  reverse_ff[1] <= csr_wdata[0];
            stc_pkg::CSR_RAMP_STEPS: ramp_ff       <= csr_wdata[15:0];
            stc_pkg::CSR_MICROSTEPS: micro_ff      <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
   end

   assign motor_sel = req_ff.motor;
   assign cur_phase = phase_ff[motor_sel];
   assign cur_dir   = dir_ff[motor_sel];

   // period bounds follow the live settings
   assign fp        = fastest_ff[motor_sel];
   assign low_p     = (fp < stc_pkg::PERIOD_FLOOR) ? stc_pkg::PERIOD_FLOOR : fp;
   assign low_ext   = {3'b000, low_p};
   assign prod_high = PROD_W'(low_p) * PROD_W'(SLOW_DIV);
   assign high_p    = (32'(prod_high) > 32'd65535) ? 16'hFFFF : 16'(prod_high);
   assign div_numer = PROD_W'(low_p) * PROD_W'(SLOW_DIV - 1);
   assign div_denom = (ramp_ff == 16'd0) ? 16'd1 : ramp_ff;

   stc_div #(
      .NUM_W (PROD_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign inc_wide = 32'(quotient) + 32'd1;
   assign inc_sat  = (inc_wide > 32'd65535) ? 16'hFFFF : inc_wide[15:0];

   // move checks
   assign raw_u      = unsigned'(req_ff.move_steps);
   assign down       = raw_u[31];
   assign mag        = down ? (32'd0 - raw_u) : raw_u;
   assign short_move = ({1'b0, mag} < {16'd0, ramp_ff, 1'b0});

   always_comb begin
      if (cur_phase != stc_pkg::PH_SLEEP) begin
         move_check = stc_pkg::MS_BUSY;
      end else if (raw_u == 32'd0) begin
         move_check = stc_pkg::MS_ZERO;
      end else if ((travel_ff[motor_sel] != 31'd0) && (mag > {1'b0, travel_ff[motor_sel]})) begin
         move_check = stc_pkg::MS_TOO_BIG;
      end else if ((down && req_ff.zero_switch_hit) || (!down && req_ff.far_switch_hit)) begin
         move_check = stc_pkg::MS_ON_SWITCH;
      end else begin
         move_check = stc_pkg::MS_OK;
      end
   end

   assign cnt_inc   = cnt_ff[motor_sel] + 8'd1;
   assign steps_dec = steps_ff[motor_sel] - 32'd1;
   assign arr_dn    = period_ff[motor_sel] - inc_ff[motor_sel];
   assign arr_up    = period_ff[motor_sel] + inc_ff[motor_sel];

   always_comb begin
      phase_in       = cur_phase;
      pos_in         = pos_ff[motor_sel];
      steps_in       = steps_ff[motor_sel];
      cnt_in         = cnt_ff[motor_sel];
      dir_in         = cur_dir;
      period_in      = period_ff[motor_sel];
      inc_in         = inc_ff[motor_sel];
      en_in          = en_ff[motor_sel];
      pin_in         = pin_ff[motor_sel];
      move_status_in = stc_pkg::MS_OK;
      case (req_ff.command)
         stc_pkg::CMD_TICK: begin
            if (cur_phase != stc_pkg::PH_SLEEP) begin
               cnt_in = cnt_inc;
               if (cnt_inc == micro_ff) begin
                  cnt_in = 8'd0;
                  // full step
                  if (cur_phase == stc_pkg::PH_STOPZ) begin
                     pos_in = 32'd0;
                  end else begin
                     steps_in = steps_dec;
                     if (steps_dec == 32'd0) begin
                        phase_in = stc_pkg::PH_STOP;
                     end
                     if (cur_dir == stc_pkg::DIR_UP) begin
                        pos_in = pos_ff[motor_sel] + 32'd1;
                     end else if (cur_dir == stc_pkg::DIR_DOWN) begin
                        pos_in = pos_ff[motor_sel] - 32'd1;
                     end
                  end
                  case (phase_in)
                     stc_pkg::PH_ACCEL: begin
                        if ((arr_dn <= low_ext) || (arr_dn > high_p)) begin
                           period_in = low_ext;
                           phase_in  = stc_pkg::PH_CRUISE;
                        end else begin
                           period_in = arr_dn;
                        end
                     end
                     stc_pkg::PH_DECEL: begin
                        if ((arr_up >= high_p) || (arr_up < low_ext)) begin
                           period_in = high_p;
                           phase_in  = stc_pkg::PH_SLOW;
                        end else begin
                           period_in = arr_up;
                        end
                     end
                     stc_pkg::PH_CRUISE: begin
                        if (steps_in <= {16'd0, ramp_ff}) begin
                           phase_in = stc_pkg::PH_DECEL;
                        end
                     end
                     stc_pkg::PH_SLOW: ;
                     default: begin
                        // stop phases power down
                        cnt_in   = 8'd0;
                        en_in    = 1'b0;
                        dir_in   = stc_pkg::DIR_NONE;
                        steps_in = 32'd0;
                        phase_in = stc_pkg::PH_SLEEP;
                     end
                  endcase
               end
            end
         end
         stc_pkg::CMD_MOVE: begin
            move_status_in = move_check;
            if (move_check == stc_pkg::MS_OK) begin
               dir_in    = down ? stc_pkg::DIR_DOWN : stc_pkg::DIR_UP;
               pin_in    = reverse_ff[motor_sel] ? !down : down;
               en_in     = 1'b1;
               steps_in  = mag;
               period_in = high_p;
               inc_in    = inc_sat;
               phase_in  = short_move ? stc_pkg::PH_SLOW : stc_pkg::PH_ACCEL;
            end
         end
         stc_pkg::CMD_STOP: begin
            if (cur_phase != stc_pkg::PH_SLEEP) begin
               phase_in = stc_pkg::PH_STOP;
            end
         end
         stc_pkg::CMD_CHECK: begin
            if (cur_phase inside {stc_pkg::PH_ACCEL, stc_pkg::PH_CRUISE,
                                  stc_pkg::PH_DECEL, stc_pkg::PH_SLOW}) begin
               if (req_ff.zero_switch_hit && (cur_dir == stc_pkg::DIR_DOWN)) begin
                  phase_in = stc_pkg::PH_STOPZ;
               end else if (req_ff.far_switch_hit && (cur_dir == stc_pkg::DIR_UP)) begin
                  phase_in = stc_pkg::PH_STOP;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            phase_ff[i]  <= stc_pkg::PH_SLEEP;
            pos_ff[i]    <= stc_pkg::POSITION_RESET;
            steps_ff[i]  <= '0;
            cnt_ff[i]    <= '0;
            dir_ff[i]    <= stc_pkg::DIR_NONE;
            period_ff[i] <= stc_pkg::PERIOD_RESET;
            inc_ff[i]    <= '0;
            en_ff[i]     <= 1'b0;
            pin_ff[i]    <= 1'b0;
         end
      end else if (cmd.commit) begin
         phase_ff[motor_sel]  <= phase_in;
         pos_ff[motor_sel]    <= pos_in;
         steps_ff[motor_sel]  <= steps_in;
         cnt_ff[motor_sel]    <= cnt_in;
         dir_ff[motor_sel]    <= dir_in;
         period_ff[motor_sel] <= period_in;
         inc_ff[motor_sel]    <= inc_in;
         en_ff[motor_sel]     <= en_in;
         pin_ff[motor_sel]    <= pin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.move_status     <= move_status_in;
         rsp_ff.phase           <= phase_in;
         rsp_ff.timer_period    <= period_in;
         rsp_ff.motor_enable    <= en_in;
         rsp_ff.direction_level <= pin_in;
         rsp_ff.position        <= signed'(pos_in);
         rsp_ff.steps_remaining <= steps_in;
      end
   end

   assign status.move_ok  = (req_ff.command == stc_pkg::CMD_MOVE) &&
                            (move_check == stc_pkg::MS_OK);
   assign status.div_busy = div_busy;
   assign rsp_word        = rsp_ff;

endmodule

@@ rtl/core/stc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_ctrl
// Sequencer: takes one request word, runs the divider for accepted moves,
// commits the motor state and hands the result word to the output register.
// ----------------------------------------------------------------------------
module stc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  stc_pkg::dp_status_type status,
   output stc_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.div_start = 1'b0;
      cmd.commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.move_ok) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DIVIDE: begin
            if (!status.div_busy) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/stepper_trapezoid_ramp_controller_core.sv @@
`timescale 1ns / 1ps
// A word is loaded (ST_IDLE), checked (ST_CHECK) and committed (ST_COMMIT); a move that
//   passes its checks also runs the ramp-increment divider (ST_DIVIDE) before the commit
// throughput: one word in flight; the next is taken the cycle after the result registers,
//   while that result may still wait at the output
// reset: synchronous; both motors asleep at position -1, settings back to defaults
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_controller_core
// Two-motor stepper controller with a linear trapezoidal ramp of the step
// timer period: ticks, moves, stops and end-switch checks per motor.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp_controller_core #(
   parameter int SLOW_DIV = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  stc_pkg::csr_index_type          csr_index,
   input  logic [stc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  stc_pkg::req_word_type           req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output stc_pkg::rsp_word_type           rsp_word
);

   stc_pkg::ctrl_cmd_type  cmd;
   stc_pkg::dp_status_type status;

   stc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   stc_dp #(
      .SLOW_DIV (SLOW_DIV)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_word  (rsp_word)
   );

endmodule

@@ dv/stepper_trapezoid_ramp_controller_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_controller_core_test
// Drives tick, move, stop and end-switch words into the two-motor ramp
// controller under several register settings, predicts every result word
// from a behavioral copy of both motors, and compares the words field by
// field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp_controller_core_test;
   import stc_pkg::*;

   localparam int SLOW_DIV = 10;
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned HOLD_AT = 500;
   localparam int unsigned HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   csr_index_type csr_index = CSR_FASTEST_A;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // settings as the block holds them
   logic [12:0] fast_period [2];
   logic [30:0] travel [2];
   logic reversed [2];
   logic [15:0] ramp_len;
   logic [7:0] step_ticks;

   // per-motor state
   phase_type phase_now [2];
   logic [31:0] step_position [2];
   logic [31:0] remaining_steps [2];
   logic [7:0] tick_count [2];
   dir_type heading [2];
   logic [15:0] period [2];
   logic [15:0] ramp_step [2];
   logic enabled [2];
   logic dir_pin [2];

   req_word_type commands_to_send [$];
   rsp_word_type reports_due [$];
   rsp_word_type want;
   bit send_idle = 1'b1;
   bit take_idle = 1'b1;
   int unsigned send_gap = 0;
   int unsigned take_gap = 0;
   int unsigned long_hold = 0;
   int unsigned quiet_cycles = 0;
   int unsigned reports_seen = 0;
   int unsigned mismatch_count = 0;

   stepper_trapezoid_ramp_controller_core #(
      .SLOW_DIV(SLOW_DIV)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   always #6 clock = ~clock;

   function automatic rsp_word_type next_motor_report(req_word_type w);
      rsp_word_type r;
      int unsigned m, lo, hi, divisor, rate;
      logic [31:0] mag;
      logic [15:0] arr;
      logic down;
      status_type st;
      m = w.motor;
      lo = (fast_period[m] < PERIOD_FLOOR) ? PERIOD_FLOOR : fast_period[m];
      hi = lo * SLOW_DIV;
      if (hi > 65535) hi = 65535;
      down = w.move_steps[31];
      mag = down ? 32'd0 - w.move_steps : w.move_steps;
      st = MS_OK;
      case (w.command)
         CMD_TICK: begin
            if (phase_now[m] != PH_SLEEP) begin
               tick_count[m] = tick_count[m] + 8'd1;
               if (tick_count[m] == step_ticks) begin
                  tick_count[m] = '0;
                  if (phase_now[m] == PH_STOPZ) begin
                     step_position[m] = '0;
                  end else begin
                     remaining_steps[m] = remaining_steps[m] - 32'd1;
                     if (remaining_steps[m] == 0) phase_now[m] = PH_STOP;
                     if (heading[m] == DIR_UP) step_position[m] = step_position[m] + 32'd1;
                     else if (heading[m] == DIR_DOWN) step_position[m] = step_position[m] - 32'd1;
                  end
                  case (phase_now[m])
                     PH_ACCEL: begin
                        arr = period[m] - ramp_step[m];
                        if (arr <= lo || arr > hi) begin
                           arr = lo[15:0];
                           phase_now[m] = PH_CRUISE;
                        end
                        period[m] = arr;
                     end
                     PH_DECEL: begin
                        arr = period[m] + ramp_step[m];
                        if (arr >= hi || arr < lo) begin
                           arr = hi[15:0];
                           phase_now[m] = PH_SLOW;
                        end
                        period[m] = arr;
                     end
                     PH_CRUISE: begin
                        if (remaining_steps[m] <= ramp_len) phase_now[m] = PH_DECEL;
                     end
                     PH_SLOW: begin
                     end
                     default: begin
                        // stopped: power the driver down right away
                        tick_count[m] = '0;
                        enabled[m] = 1'b0;
                        heading[m] = DIR_NONE;
                        remaining_steps[m] = '0;
                        phase_now[m] = PH_SLEEP;
                     end
                  endcase
               end
            end
         end
         CMD_MOVE: begin
            if (phase_now[m] != PH_SLEEP) st = MS_BUSY;
            else if (w.move_steps == 0) st = MS_ZERO;
            else if (travel[m] != 0 && mag > travel[m]) st = MS_TOO_BIG;
            else if (down ? w.zero_switch_hit : w.far_switch_hit) st = MS_ON_SWITCH;
            else begin
               heading[m] = down ? DIR_DOWN : DIR_UP;
               dir_pin[m] = down ^ reversed[m];
               enabled[m] = 1'b1;
               remaining_steps[m] = mag;
               period[m] = hi[15:0];
               divisor = (ramp_len == 0) ? 1 : ramp_len;
               rate = lo * (SLOW_DIV - 1) / divisor + 1;
               ramp_step[m] = (rate > 65535) ? 16'hFFFF : rate[15:0];
               phase_now[m] = (mag < 32'd2 * ramp_len) ? PH_SLOW : PH_ACCEL;
            end
         end
         CMD_STOP: begin
            if (phase_now[m] != PH_SLEEP) phase_now[m] = PH_STOP;
         end
         default: begin
            if (phase_now[m] >= PH_ACCEL && phase_now[m] <= PH_SLOW) begin
               if (w.zero_switch_hit && heading[m] == DIR_DOWN) phase_now[m] = PH_STOPZ;
               else if (w.far_switch_hit && heading[m] == DIR_UP) phase_now[m] = PH_STOP;
            end
         end
      endcase
      r.move_status = st;
      r.phase = phase_now[m];
      r.timer_period = period[m];
      r.motor_enable = enabled[m];
      r.direction_level = dir_pin[m];
      r.position = step_position[m];
      r.steps_remaining = remaining_steps[m];
      return r;
   endfunction

   function automatic req_word_type make_word(command_type c, logic axis, logic [31:0] steps,
                                              logic z, logic f);
      req_word_type w;
      w.command = c;
      w.motor = axis;
      w.move_steps = steps;
      w.zero_switch_hit = z;
      w.far_switch_hit = f;
      return w;
   endfunction

   function automatic int unsigned draw_wait(bit on);
      return on ? $urandom_range(0, 14) : 0;
   endfunction

   task automatic compare_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s expected %0h actual %0h", name, expected, actual);
         mismatch_count++;
      end
   endtask

   task automatic write_setting(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_FASTEST_A: fast_period[0] = value[12:0];
         CSR_FASTEST_B: fast_period[1] = value[12:0];
         CSR_TRAVEL_A: travel[0] = value[30:0];
         CSR_TRAVEL_B: travel[1] = value[30:0];
         CSR_REVERSE_A: reversed[0] = value[0];
         CSR_REVERSE_B: reversed[1] = value[0];
         CSR_RAMP_STEPS: ramp_len = value[15:0];
         default: step_ticks = value[7:0];
      endcase
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (commands_to_send.size() != 0 || req_valid || reports_due.size() != 0);
      repeat (24) @(negedge clock);
   endtask

   // mostly a move followed by up to 300 ticks toward its end, with some noise
   task automatic queue_random_items(int unsigned count);
      int unsigned sent, per_step, ticks, roll;
      logic axis;
      logic [31:0] mag;
      sent = 0;
      per_step = (step_ticks == 0) ? 256 : step_ticks;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 7) begin
            axis = 1'($urandom_range(0, 1));
            mag = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
            commands_to_send.push_back(make_word(CMD_MOVE, axis,
               $urandom_range(0, 1) ? 32'd0 - mag : mag,
               $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0));
            sent++;
            ticks = mag * per_step + $urandom_range(0, per_step);
            if (ticks > 300) ticks = 300;
            if (ticks > count - sent) ticks = count - sent;
            repeat (ticks) begin
               roll = $urandom_range(0, 63);
               if (roll == 0) begin
                  commands_to_send.push_back(make_word(CMD_STOP, axis, $urandom(), 1'b0, 1'b0));
               end else if (roll < 3) begin
                  commands_to_send.push_back(make_word(CMD_CHECK, axis, $urandom(),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
               end else if (roll == 3) begin
                  commands_to_send.push_back(make_word(CMD_MOVE, axis,
                     $urandom_range(0, 80) - 32'd40, 1'b0, 1'b0));
               end else if (roll < 10) begin
                  commands_to_send.push_back(make_word(CMD_TICK, ~axis, $urandom(), 1'b0, 1'b0));
               end else begin
                  commands_to_send.push_back(make_word(CMD_TICK, axis, $urandom(), 1'b0, 1'b0));
               end
               sent++;
            end
         end else begin
            commands_to_send.push_back(make_word(command_type'($urandom_range(0, 3)),
               1'($urandom_range(0, 1)),
               $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 80) - 32'd40,
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            sent++;
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            reports_due.push_back(next_motor_report(req_word));
            send_gap = draw_wait(send_idle);
         end
         if (req_valid && req_stall) begin
            // word held until taken
         end else if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (commands_to_send.size() != 0) begin
            req_word <= commands_to_send.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (reports_due.size() == 0) begin
               $error("result word with no expectation waiting");
               mismatch_count++;
            end else begin
               want = reports_due.pop_front();
               compare_field("move_status", want.move_status, rsp_word.move_status);
               compare_field("phase", want.phase, rsp_word.phase);
               compare_field("timer_period", want.timer_period, rsp_word.timer_period);
               compare_field("motor_enable", want.motor_enable, rsp_word.motor_enable);
               compare_field("direction_level", want.direction_level,
                             rsp_word.direction_level);
               compare_field("position", want.position, rsp_word.position);
               compare_field("steps_remaining", want.steps_remaining,
                             rsp_word.steps_remaining);
            end
            reports_seen++;
            take_gap = draw_wait(take_idle);
            if (reports_seen == HOLD_AT) long_hold = HOLD_CYCLES;
         end
         if (long_hold != 0) begin
            long_hold--;
            rsp_stall <= 1'b1;
         end else if (take_gap != 0) begin
            take_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] cfg [8];
      int unsigned item_count;
      for (int i = 0; i < 2; i++) begin
         fast_period[i] = FASTEST_RESET;
         travel[i] = '0;
         reversed[i] = 1'b0;
         phase_now[i] = PH_SLEEP;
         step_position[i] = POSITION_RESET;
         remaining_steps[i] = '0;
         tick_count[i] = '0;
         heading[i] = DIR_NONE;
         period[i] = PERIOD_RESET;
         ramp_step[i] = '0;
         enabled[i] = 1'b0;
         dir_pin[i] = 1'b0;
      end
      ramp_len = RAMP_STEPS_RESET;
      step_ticks = MICROSTEPS_RESET;
      item_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset settings
      commands_to_send.push_back(make_word(CMD_TICK, 1'b0, 32'd0, 1'b0, 1'b0));
      commands_to_send.push_back(make_word(CMD_STOP, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0));
      commands_to_send.push_back(make_word(CMD_CHECK, 1'b0, 32'd0, 1'b1, 1'b1));
      commands_to_send.push_back(make_word(CMD_MOVE, 1'b0, 32'd0, 1'b0, 1'b0));
      commands_to_send.push_back(make_word(CMD_MOVE, 1'b0, -32'sd7, 1'b1, 1'b0));
      commands_to_send.push_back(make_word(CMD_MOVE, 1'b0, 32'd7, 1'b0, 1'b1));
      commands_to_send.push_back(make_word(CMD_MOVE, 1'b1, 32'h8000_0000, 1'b0, 1'b1));
      commands_to_send.push_back(make_word(CMD_MOVE, 1'b1, 32'd1, 1'b0, 1'b0));
      commands_to_send.push_back(make_word(CMD_CHECK, 1'b1, 32'd0, 1'b0, 1'b1));
      commands_to_send.push_back(make_word(CMD_CHECK, 1'b1, 32'd0, 1'b1, 1'b0));
      repeat (16) commands_to_send.push_back(make_word(CMD_TICK, 1'b1, 32'd0, 1'b0, 1'b0));
      commands_to_send.push_back(make_word(CMD_MOVE, 1'b0, 32'h7FFF_FFFF, 1'b0, 1'b0));
      commands_to_send.push_back(make_word(CMD_STOP, 1'b0, 32'd0, 1'b0, 1'b0));
      wait_drained();

      for (int p = 1; p <= 6; p++) begin
         case (p)
            1: begin
               cfg = '{31'd2, 31'd6553, 31'd0, 31'd30, 31'd1, 31'd0, 31'd1, 31'd1};
               item_count = 260;
               send_idle = 1'b1;
               take_idle = 1'b1;
            end
            2: begin
               cfg = '{31'd6553, 31'd2, 31'h7FFF_FFFF, 31'd0, 31'd0, 31'd1, 31'd3, 31'd2};
               item_count = 260;
               send_idle = 1'b0;
               take_idle = 1'b0;
            end
            3: begin
               cfg = '{31'd0, 31'd8191, 31'd5, 31'd0, 31'd1, 31'd1, 31'd1, 31'd3};
               item_count = 250;
               send_idle = 1'b1;
               take_idle = 1'b0;
            end
            4: begin
               cfg[0] = 31'($urandom_range(2, 6553));
               cfg[1] = 31'($urandom_range(0, 8191));
               cfg[2] = 31'($urandom_range(0, 40));
               cfg[3] = 31'($urandom_range(0, 40));
               cfg[4] = 31'($urandom_range(0, 1));
               cfg[5] = 31'($urandom_range(0, 1));
               cfg[6] = 31'($urandom_range(1, 6));
               cfg[7] = 31'($urandom_range(1, 4));
               item_count = 260;
               send_idle = 1'b0;
               take_idle = 1'b1;
            end
            5: begin
               // zero ramp length and 256 ticks per full step
               cfg = '{31'd8191, 31'd0, 31'd0, 31'd1, 31'd0, 31'd1, 31'd0, 31'd0};
               item_count = 260;
               send_idle = 1'b1;
               take_idle = 1'b1;
            end
            default: begin
               cfg = '{31'd500, 31'd1, 31'd12, 31'h7FFF_FFFF, 31'd1, 31'd0, 31'd65535,
                       31'd255};
               item_count = 250;
               send_idle = 1'b1;
               take_idle = 1'b1;
            end
         endcase
         for (int i = 0; i < 8; i++) write_setting(csr_index_type'(i), cfg[i]);
         queue_random_items(item_count);
         wait_drained();
      end

      repeat (30) @(negedge clock);
      if (mismatch_count == 0 && reports_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
